@@ rtl/core/etdt_pkg.sv @@
// Shared types, constants and the month length table for the epoch calendar converter.
package etdt_pkg;

  localparam int unsigned SubW = 18;

  localparam logic [SubW-1:0] SECS_PER_DAY  = 18'd86400;
  localparam logic [SubW-1:0] SECS_PER_HOUR = 18'd3600;
  localparam logic [SubW-1:0] SECS_PER_MIN  = 18'd60;

  localparam logic [4:0] DAY_LAST  = 5'd31;
  localparam logic [4:0] HOUR_LAST = 5'd16;
  localparam logic [4:0] MIN_LAST  = 5'd11;

  localparam logic [11:0] FIRST_YEAR   = 12'd1970;
  localparam logic [6:0]  FIRST_MOD100 = 7'd70;
  localparam logic [8:0]  FIRST_MOD400 = 9'd370;
  localparam logic [6:0]  MOD100_LAST  = 7'd99;
  localparam logic [8:0]  MOD400_LAST  = 9'd399;

  localparam logic [8:0] DAYS_YEAR      = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH
  } etdt_state_e;

  typedef struct packed {
    logic init;
    logic advance;
  } etdt_year_ctl_t;

  typedef struct packed {
    logic [SubW-1:0] diff;
    logic            borrow;
    logic            gt;
  } etdt_sub_res_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/etdt_sub_unit.sv @@
// Shared subtract and compare unit used by every step of the conversion.
module etdt_sub_unit (
  input  logic [etdt_pkg::SubW-1:0] a_i,
  input  logic [etdt_pkg::SubW-1:0] b_i,
  output etdt_pkg::etdt_sub_res_t   res_o
);
  import etdt_pkg::*;

  logic [SubW:0] full;

  assign full = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    res_o.diff   = full[SubW-1:0];
    res_o.borrow = full[SubW];
    res_o.gt     = !full[SubW] && (full[SubW-1:0] != '0);
  end

endmodule

@@ rtl/core/etdt_leap_tracker.sv @@
// Year counter with running remainders by 100 and 400 that give the leap year flag.
module etdt_leap_tracker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  etdt_pkg::etdt_year_ctl_t ctl_i,
  output logic [11:0]              year_o,
  output logic                     leap_o
);
  import etdt_pkg::*;

  logic [11:0] year_q, year_d;
  logic [6:0]  m100_q, m100_d;
  logic [8:0]  m400_q, m400_d;

  always_comb begin
    year_d = year_q;
    m100_d = m100_q;
    m400_d = m400_q;
    if (ctl_i.init) begin
      year_d = FIRST_YEAR;
      m100_d = FIRST_MOD100;
      m400_d = FIRST_MOD400;
    end else if (ctl_i.advance) begin
      year_d = year_q + 12'd1;
      m100_d = (m100_q == MOD100_LAST) ? 7'd0 : m100_q + 7'd1;
      m400_d = (m400_q == MOD400_LAST) ? 9'd0 : m400_q + 9'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= FIRST_YEAR;
      m100_q <= FIRST_MOD100;
      m400_q <= FIRST_MOD400;
    end else begin
      year_q <= year_d;
      m100_q <= m100_d;
      m400_q <= m400_d;
    end
  end

  assign year_o = year_q;
  assign leap_o = ((year_q[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m100_q <= MOD100_LAST) && (m400_q <= MOD400_LAST))
    else $error("year remainder out of range");

  a_mod_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m100_q[1:0] == year_q[1:0]) && (m400_q[1:0] == year_q[1:0]))
    else $error("year remainders disagree with year");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.advance && !ctl_i.init) |=> (year_q == $past(year_q) + 12'd1))
    else $error("year did not advance");

endmodule

@@ rtl/core/epoch_seconds_to_datetime_core.sv @@
// Top level: sequencer and registers of the epoch second to calendar date converter.
// Steps: bit-serial division by the seconds per day, hour and minute, then a search over the
// years past 1970 (0..136) and the months (1..12), all on the single shared subtractor.
// Throughput: one item at a time; a new beat is taken once the previous one is in the output
// register, so the next item may start while a result still waits.
// Reset: asynchronous, active low; clears the sequencer and the output valid flag.
module epoch_seconds_to_datetime_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] cal_year_o,
  output logic [3:0]  cal_month_o,
  output logic [4:0]  cal_day_o,
  output logic [4:0]  clock_hour_o,
  output logic [5:0]  clock_minute_o,
  output logic [5:0]  clock_second_o
);
  import etdt_pkg::*;

  etdt_state_e state_q, state_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] days_q, days_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [3:0]  month_q, month_d;

  logic        out_valid_q, out_valid_d;
  logic [11:0] cal_year_q, cal_year_d;
  logic [3:0]  cal_month_q, cal_month_d;
  logic [4:0]  cal_day_q, cal_day_d;
  logic [4:0]  clock_hour_q, clock_hour_d;
  logic [5:0]  clock_minute_q, clock_minute_d;
  logic [5:0]  clock_second_q, clock_second_d;

  logic [SubW-1:0] sub_a, sub_b, trial;
  etdt_sub_res_t   sub_res;
  logic [16:0]     div_rem;
  logic [31:0]     div_quo;
  etdt_year_ctl_t  year_ctl;
  logic [11:0]     year;
  logic            leap;
  logic [8:0]      year_len;
  logic            out_free;

  etdt_sub_unit u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  etdt_leap_tracker u_leap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (year_ctl),
    .year_o (year),
    .leap_o (leap)
  );

  assign trial    = {rem_q, quo_q[31]};
  assign div_rem  = sub_res.borrow ? trial[16:0] : sub_res.diff[16:0];
  assign div_quo  = {quo_q[30:0], ~sub_res.borrow};
  assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (state_q)
      S_DAY:   begin sub_a = trial; sub_b = SECS_PER_DAY; end
      S_HOUR:  begin sub_a = trial; sub_b = SECS_PER_HOUR; end
      S_MIN:   begin sub_a = trial; sub_b = SECS_PER_MIN; end
      S_YEAR:  begin sub_a = {2'd0, days_q}; sub_b = {9'd0, year_len}; end
      S_MONTH: begin sub_a = {2'd0, days_q}; sub_b = {13'd0, month_days(month_q, leap)}; end
      default: begin sub_a = '0; sub_b = '0; end
    endcase
  end

  always_comb begin
    state_d        = state_q;
    quo_d          = quo_q;
    rem_d          = rem_q;
    cnt_d          = cnt_q;
    days_d         = days_q;
    hour_d         = hour_q;
    minute_d       = minute_q;
    month_d        = month_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cal_year_d     = cal_year_q;
    cal_month_d    = cal_month_q;
    cal_day_d      = cal_day_q;
    clock_hour_d   = clock_hour_q;
    clock_minute_d = clock_minute_q;
    clock_second_d = clock_second_q;
    year_ctl       = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          quo_d         = epoch_seconds_i;
          rem_d         = '0;
          cnt_d         = DAY_LAST;
          year_ctl.init = 1'b1;
          state_d       = S_DAY;
        end
      end
      S_DAY: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          days_d  = div_quo[15:0] + 16'd1;
          quo_d   = {div_rem, 15'd0};
          rem_d   = '0;
          cnt_d   = HOUR_LAST;
          state_d = S_HOUR;
        end
      end
      S_HOUR: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          hour_d  = div_quo[4:0];
          quo_d   = {div_rem[11:0], 20'd0};
          rem_d   = '0;
          cnt_d   = MIN_LAST;
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          minute_d = div_quo[5:0];
          state_d  = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sub_res.gt) begin
          days_d           = sub_res.diff[15:0];
          year_ctl.advance = 1'b1;
        end else begin
          month_d = MONTH_JAN;
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sub_res.gt && (month_q != MONTH_DEC)) begin
          days_d  = sub_res.diff[15:0];
          month_d = month_q + 4'd1;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          cal_year_d     = year;
          cal_month_d    = month_q;
          cal_day_d      = sub_res.gt ? sub_res.diff[4:0] : days_q[4:0];
          clock_hour_d   = hour_q;
          clock_minute_d = minute_q;
          clock_second_d = rem_q[5:0];
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q          <= quo_d;
    rem_q          <= rem_d;
    days_q         <= days_d;
    hour_q         <= hour_d;
    minute_q       <= minute_d;
    month_q        <= month_d;
    cal_year_q     <= cal_year_d;
    cal_month_q    <= cal_month_d;
    cal_day_q      <= cal_day_d;
    clock_hour_q   <= clock_hour_d;
    clock_minute_q <= clock_minute_d;
    clock_second_q <= clock_second_d;
  end

  assign out_valid_o    = out_valid_q;
  assign cal_year_o     = cal_year_q;
  assign cal_month_o    = cal_month_q;
  assign cal_day_o      = cal_day_q;
  assign clock_hour_o   = clock_hour_q;
  assign clock_minute_o = clock_minute_q;
  assign clock_second_o = clock_second_q;

  a_days_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MONTH) |-> (days_q != 16'd0))
    else $error("day count reached zero in month search");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((clock_hour_o < 5'd24) && (clock_minute_o < 6'd60) &&
                     (clock_second_o < 6'd60)))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cal_month_o >= MONTH_JAN) && (cal_month_o <= MONTH_DEC) &&
                     (cal_day_o != 5'd0)))
    else $error("date out of range");

endmodule
